// File: rtl/dacc_pkg.sv
// Shared types and constants for the decimal accumulator processor.
`default_nettype none
package dacc_pkg;

   localparam int unsigned MEM_WORDS     = 100;
   localparam int unsigned DEF_WORD_BITS = 32;
   localparam int unsigned DATA_BITS     = 32;
   localparam int unsigned LOAD_ADDR_BITS = 7;
   localparam int unsigned ADDR_BITS     = $clog2(MEM_WORDS);
   localparam int unsigned STATUS_BITS   = 3;
   localparam int unsigned DEC_BASE      = 100;
   localparam int unsigned DEC_LIMIT     = 10 * DEC_BASE;
   localparam int unsigned DIGIT_BITS    = 4;
   localparam int unsigned SMALL_BITS    = $clog2(DEC_LIMIT);

   typedef enum logic [DIGIT_BITS-1:0] {
      OP_BAD    = 4'd0,
      OP_LOAD   = 4'd1,
      OP_STORE  = 4'd2,
      OP_ADD    = 4'd3,
      OP_SUB    = 4'd4,
      OP_HALT   = 4'd5,
      OP_INPUT  = 4'd8,
      OP_OUTPUT = 4'd9
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_LOADED   = 3'd0,
      ST_EXECUTED = 3'd1,
      ST_OUTPUT   = 3'd2,
      ST_HALTED   = 3'd3,
      ST_INVALID  = 3'd4,
      ST_IGNORED  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_FETCH = 2'd1,
      S_EXEC  = 2'd2
   } state_type;

endpackage
`default_nettype wire

// File: rtl/dacc_req_if.sv
// Request channel: memory load or single-step beats.
`default_nettype none
interface dacc_req_if import dacc_pkg::*; ();
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic        [LOAD_ADDR_BITS-1:0] load_address;
   logic signed [DATA_BITS-1:0]      data_value;

   modport source (output valid, output mode, output load_address, output data_value,
                   input ready);
   modport sink   (input valid, input mode, input load_address, input data_value,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/dacc_rsp_if.sv
// Response channel: status and machine state after each beat.
`default_nettype none
interface dacc_rsp_if import dacc_pkg::*; ();
   logic                             valid;
   logic                             ready;
   logic        [STATUS_BITS-1:0]    status;
   logic signed [DATA_BITS-1:0]      out_value;
   logic        [LOAD_ADDR_BITS-1:0] next_pc;
   logic signed [DATA_BITS-1:0]      accumulator;

   modport source (output valid, output status, output out_value, output next_pc,
                   output accumulator, input ready);
   modport sink   (input valid, input status, input out_value, input next_pc,
                   input accumulator, output ready);
endinterface
`default_nettype wire

// File: rtl/decimal_accumulator_cpu_top.sv
// Decimal accumulator processor: sequencer around a synchronous word memory.
//
// req_chan carries one beat per item: mode 0 writes data_value into the
// memory word at load_address, mode 1 executes the instruction at the
// program counter (INPUT instructions store data_value). rsp_chan returns
// one beat per request with status, reported word, program counter and
// accumulator after the item.
// A load or an ignored step goes straight from the idle state into the
// output register; an executed step runs instruction fetch, operand read,
// then execute and write back, with reads through the single read port.
// A request is held in the input register until its beat is issued, and the
// next one is taken in that same cycle, so loads stream at one load every
// cycle while rsp_chan does not stall; a new step waits for the last beat.
// Reset clears the accumulator, the program counter, the stop flag and the
// per-word valid bits, so every word reads as zero until written; no
// clearing pass is needed and the block is ready straight out of reset.
// When rsp_chan stalls, the finished beat is held in the output register
// and the sequencer waits with its memory read held until it drains.
`default_nettype none
module decimal_accumulator_cpu_top import dacc_pkg::*; #(
   parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   dacc_req_if.sink   req_chan,
   dacc_rsp_if.source rsp_chan
);

   logic [WORD_BITS-1:0] mem [MEM_WORDS];
   logic                 mem_vld_ff [MEM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [ADDR_BITS-1:0] rd_addr;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic                        buf_valid_ff, buf_valid_in;
   logic                        buf_mode_ff;
   logic [LOAD_ADDR_BITS-1:0]   buf_addr_ff;
   logic signed [DATA_BITS-1:0] buf_data_ff;
   logic                        buf_take;

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] pc_ff, pc_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 stop_ff, stop_in;
   op_type               op_ff, op_in;
   logic [ADDR_BITS-1:0] opaddr_ff, opaddr_in;

   logic                        out_valid_ff, out_valid_in;
   status_type                  out_status_ff, out_status_in;
   logic signed [DATA_BITS-1:0] out_value_ff, out_value_in;
   logic [ADDR_BITS-1:0]        out_pc_ff;
   logic signed [DATA_BITS-1:0] out_acc_ff;
   logic                        emit;
   logic                        out_free;

   logic [WORD_BITS-1:0]  word_rd;
   logic [WORD_BITS-1:0]  in_word;
   logic                  dec_small;
   logic [SMALL_BITS-1:0] dec_low;
   logic [DIGIT_BITS-1:0] dec_digit;
   op_type                dec_op;
   logic [ADDR_BITS-1:0]  dec_addr;

   assign word_rd  = rd_vld_ff ? rd_data_ff : '0;
   assign in_word  = WORD_BITS'(buf_data_ff);
   assign out_free = !out_valid_ff || rsp_chan.ready;

   assign req_chan.ready = !buf_valid_ff || buf_take;

   // split the fetched word into decimal opcode and address
   assign dec_small = !word_rd[WORD_BITS-1] && (word_rd < WORD_BITS'(DEC_LIMIT));
   assign dec_low   = word_rd[SMALL_BITS-1:0];

   always_comb begin
      dec_digit = '0;
      for (int k = 1; k <= 9; k++) begin
         if (dec_low >= SMALL_BITS'(k * DEC_BASE)) begin
            dec_digit = DIGIT_BITS'(k);
         end
      end
      unique case (dec_digit)
         OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_HALT, OP_INPUT, OP_OUTPUT: begin
            dec_op = dec_small ? op_type'(dec_digit) : OP_BAD;
         end
         default: begin
            dec_op = OP_BAD;
         end
      endcase
      if (dec_small) begin
         dec_addr = ADDR_BITS'(dec_low - SMALL_BITS'(dec_digit * DEC_BASE));
      end else begin
         dec_addr = '0;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = pc_ff;
         S_FETCH: rd_addr = dec_addr;
         S_EXEC:  rd_addr = opaddr_ff;
         default: rd_addr = pc_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      acc_in        = acc_ff;
      stop_in       = stop_ff;
      op_in         = op_ff;
      opaddr_in     = opaddr_ff;
      wr_en         = 1'b0;
      wr_addr       = opaddr_ff;
      wr_data       = in_word;
      emit          = 1'b0;
      out_status_in = ST_EXECUTED;
      out_value_in  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (buf_valid_ff) begin
               if (!buf_mode_ff) begin
                  if (out_free) begin
                     emit          = 1'b1;
                     out_status_in = ST_LOADED;
                     wr_en         = (buf_addr_ff < LOAD_ADDR_BITS'(MEM_WORDS));
                     wr_addr       = ADDR_BITS'(buf_addr_ff);
                  end
               end else if (stop_ff) begin
                  if (out_free) begin
                     emit          = 1'b1;
                     out_status_in = ST_IGNORED;
                  end
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            op_in     = dec_op;
            opaddr_in = dec_addr;
            pc_in     = (pc_ff == ADDR_BITS'(MEM_WORDS - 1)) ? '0 : pc_ff + 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               unique case (op_ff)
                  OP_LOAD: acc_in = word_rd;
                  OP_STORE: begin
                     wr_en   = 1'b1;
                     wr_data = acc_ff;
                  end
                  OP_ADD: acc_in = acc_ff + word_rd;
                  OP_SUB: acc_in = acc_ff - word_rd;
                  OP_HALT: begin
                     stop_in       = 1'b1;
                     out_status_in = ST_HALTED;
                  end
                  OP_INPUT: wr_en = 1'b1;
                  OP_OUTPUT: begin
                     out_status_in = ST_OUTPUT;
                     out_value_in  = DATA_BITS'($signed(word_rd));
                  end
                  default: begin
                     stop_in       = 1'b1;
                     out_status_in = ST_INVALID;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      buf_take     = emit;
      buf_valid_in = (buf_valid_ff && !buf_take) || req_chan.valid;
      out_valid_in = emit || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         stop_ff      <= 1'b0;
         buf_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         stop_ff      <= stop_in;
         buf_valid_ff <= buf_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      opaddr_ff <= opaddr_in;
      if (req_chan.valid && req_chan.ready) begin
         buf_mode_ff <= req_chan.mode;
         buf_addr_ff <= req_chan.load_address;
         buf_data_ff <= req_chan.data_value;
      end
      if (emit) begin
         out_status_ff <= out_status_in;
         out_value_ff  <= out_value_in;
         out_pc_ff     <= pc_ff;
         out_acc_ff    <= DATA_BITS'($signed(acc_in));
      end
   end

   // word store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_WORDS; i++) begin
            mem_vld_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            mem_vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= mem_vld_ff[rd_addr];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.out_value   = out_value_ff;
   assign rsp_chan.next_pc     = LOAD_ADDR_BITS'(out_pc_ff);
   assign rsp_chan.accumulator = out_acc_ff;

endmodule
`default_nettype wire
